/* src/sawr_pkg.sv */
`default_nettype none

package sawr_pkg;

    localparam logic [7:0]  ACK_CTRL    = 8'h6A;
    localparam logic [3:0]  NIB_FULL    = 4'b1111;
    localparam logic [10:0] INDEX_MAX   = 11'h7FF;
    localparam logic [10:0] HEADER_LEN  = 11'd4;
    localparam logic [10:0] IDX_SEQ     = 11'd1;
    localparam logic [10:0] IDX_LEN_LO  = 11'd2;
    localparam logic [10:0] IDX_LEN_HI  = 11'd3;
    localparam int          SRC_BITS    = 16;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_PENDING   = 2'd0,
        VERDICT_ACCEPTED  = 2'd1,
        VERDICT_DUPLICATE = 2'd2,
        VERDICT_DISCARDED = 2'd3
    } verdict_t;

    // Everything the emitter needs to replay the results of one input item.
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload;
        verdict_t   verdict;      // pending: no verdict for this item
        logic [7:0] seq;
        logic [3:0] ack_nib;
    } bundle_t;

    // 4-bit add with end-around carry
    function automatic logic [3:0] nib_add(input logic [3:0] s, input logic [3:0] nib);
        logic [4:0] t;
        begin
            t = {1'b0, s} + {1'b0, nib};
            nib_add = t[4] ? (t[3:0] + 4'd1) : t[3:0];
        end
    endfunction

    // high nibble first, then low nibble
    function automatic logic [3:0] byte_add(input logic [3:0] s, input logic [7:0] b);
        logic [3:0] t;
        begin
            t = nib_add(s, b[7:4]);
            byte_add = nib_add(t, b[3:0]);
        end
    endfunction

endpackage

`default_nettype wire

/* src/stop_and_wait_receiver_top.sv */
`default_nettype none

// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata {src_address, seg_byte}, s_tuser first,
//                                    s_tlast last
// m_*       out  m_tvalid/m_tready   m_tdata {6'b0, verdict, out_byte}, m_tuser kind,
//                                    m_tlast end_of_run
// cfg_*     in   cfg_valid/cfg_ready cfg_data expected_source (always ready)
//
// A byte sits in the input register while the checker logic forms its results; the
// edge on which it advances loads them into the emitter, which sends one per cycle.
// Payload and header bytes flow at one byte per cycle; a last byte holds the emitter
// for up to five transfers (payload plus a 4-byte ACK) and stalls the input meanwhile.
// Reset (rst_n, async, active low) clears the expected sequence, the source register
// and all segment state; m_tready low holds the emitter, which holds the input register.
module stop_and_wait_receiver_top #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] seg_byte, [23:8] src_address
    input  wire logic        s_tuser,   // [0] first
    input  wire logic        s_tlast,
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [9:8] verdict, [15:10] zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import sawr_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  seg_byte_reg;
    logic [15:0] src_address_reg;
    logic        first_reg;
    logic        last_reg;

    logic        advance;
    logic        emit_free;
    logic        bundle_valid;
    bundle_t     bundle;

    // Move the held byte into the checker whenever the emitter can take its results.
    assign advance   = in_valid_reg && emit_free;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Capture a new byte on each slave transfer.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            seg_byte_reg    <= s_tdata[7:0];
            src_address_reg <= s_tdata[23:8];
            first_reg       <= s_tuser;
            last_reg        <= s_tlast;
        end
    end

    sawr_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .advance      (advance),
        .seg_byte     (seg_byte_reg),
        .src_address  (src_address_reg),
        .first        (first_reg),
        .last         (last_reg),
        .bundle       (bundle),
        .bundle_valid (bundle_valid)
    );

    sawr_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && bundle_valid),
        .bundle   (bundle),
        .free     (emit_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* src/sawr_core.sv */
`default_nettype none

module sawr_core #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [15:0]      cfg_data,
    input  wire logic             advance,
    input  wire logic [7:0]       seg_byte,
    input  wire logic [15:0]      src_address,
    input  wire logic             first,
    input  wire logic             last,
    output sawr_pkg::bundle_t     bundle,
    output logic                  bundle_valid
);
    import sawr_pkg::*;

    localparam int CMP_BITS = (ADDR_BITS < SRC_BITS) ? ADDR_BITS : SRC_BITS;

    logic [15:0] expected_source_reg;
    logic        expected_seq_reg, expected_seq_next;
    logic [3:0]  nibble_sum_reg, nibble_sum_next;
    logic [10:0] byte_index_reg, byte_index_next;
    logic [9:0]  declared_length_reg, declared_length_next;
    logic [7:0]  seq_field_reg, seq_field_next;
    logic        source_ok_reg, source_ok_next;

    logic [3:0]  sum_cur, sum_upd;
    logic [10:0] idx_cur, idx_upd, span_upd;
    logic [9:0]  len_cur, len_upd;
    logic [7:0]  seq_cur, seq_upd;
    logic        ok_cur, in_range, full, seq_match;
    verdict_t    verdict;

    always_comb
    begin
        // first byte restarts the segment
        sum_cur = first ? 4'd0 : nibble_sum_reg;
        idx_cur = first ? 11'd0 : byte_index_reg;
        len_cur = first ? 10'd0 : declared_length_reg;
        seq_cur = first ? 8'd0 : seq_field_reg;
        ok_cur  = first ? (src_address[CMP_BITS-1:0] == expected_source_reg[CMP_BITS-1:0])
                        : source_ok_reg;

        in_range = (idx_cur < HEADER_LEN) || (idx_cur < (HEADER_LEN + {1'b0, len_cur}));
        sum_upd  = in_range ? byte_add(sum_cur, seg_byte) : sum_cur;
        seq_upd  = (in_range && idx_cur == IDX_SEQ) ? seg_byte : seq_cur;
        len_upd  = len_cur;
        if (in_range && idx_cur == IDX_LEN_LO)
        begin
            len_upd = {len_cur[9:8], seg_byte};
        end
        else if (in_range && idx_cur == IDX_LEN_HI)
        begin
            len_upd = {seg_byte[1:0], len_cur[7:0]};
        end
        idx_upd  = (idx_cur == INDEX_MAX) ? idx_cur : (idx_cur + 11'd1);

        span_upd  = HEADER_LEN + {1'b0, len_upd};
        full      = idx_upd >= span_upd;
        seq_match = seq_upd == {7'd0, expected_seq_reg};
        if (full && ok_cur && seq_match && sum_upd == NIB_FULL)
        begin
            verdict = VERDICT_ACCEPTED;
        end
        else if (full && ok_cur && !seq_match)
        begin
            verdict = VERDICT_DUPLICATE;
        end
        else
        begin
            verdict = VERDICT_DISCARDED;
        end

        bundle.payload_valid = in_range && (idx_cur >= HEADER_LEN);
        bundle.payload       = seg_byte;
        bundle.verdict       = last ? verdict : VERDICT_PENDING;
        bundle.seq           = seq_upd;
        bundle.ack_nib       = ~byte_add(byte_add(4'd0, ACK_CTRL), seq_upd);
        bundle_valid         = bundle.payload_valid || last;

        // after a verdict drop all segment state
        expected_seq_next    = expected_seq_reg ^ (last && verdict == VERDICT_ACCEPTED);
        nibble_sum_next      = last ? 4'd0  : sum_upd;
        byte_index_next      = last ? 11'd0 : idx_upd;
        declared_length_next = last ? 10'd0 : len_upd;
        seq_field_next       = last ? 8'd0  : seq_upd;
        source_ok_next       = last ? 1'b0  : ok_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_source_reg <= '0;
            expected_seq_reg    <= 1'b0;
            nibble_sum_reg      <= '0;
            byte_index_reg      <= '0;
            declared_length_reg <= '0;
            seq_field_reg       <= '0;
            source_ok_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                expected_source_reg <= cfg_data;
            end
            if (advance)
            begin
                expected_seq_reg    <= expected_seq_next;
                nibble_sum_reg      <= nibble_sum_next;
                byte_index_reg      <= byte_index_next;
                declared_length_reg <= declared_length_next;
                seq_field_reg       <= seq_field_next;
                source_ok_reg       <= source_ok_next;
            end
        end
    end

endmodule

`default_nettype wire

/* src/sawr_emit.sv */
`default_nettype none

module sawr_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire sawr_pkg::bundle_t bundle,
    output logic                   free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);
    import sawr_pkg::*;

    logic       busy_reg, busy_next;
    logic       pend_payload_reg, pend_payload_next;
    logic [7:0] payload_reg;
    verdict_t   verdict_reg;
    logic [7:0] seq_reg;
    logic [3:0] ack_nib_reg;
    logic [1:0] ack_step_reg, ack_step_next;

    kind_t      kind;
    verdict_t   verdict_out;
    logic [7:0] byte_out;
    logic       xfer;

    always_comb
    begin
        if (pend_payload_reg)
        begin
            kind        = KIND_PAYLOAD;
            byte_out    = payload_reg;
            verdict_out = VERDICT_PENDING;
            m_tlast     = (verdict_reg == VERDICT_PENDING);
        end
        else if (verdict_reg == VERDICT_DISCARDED)
        begin
            kind        = KIND_VERDICT;
            byte_out    = 8'd0;
            verdict_out = verdict_reg;
            m_tlast     = 1'b1;
        end
        else
        begin
            kind        = KIND_ACK;
            verdict_out = verdict_reg;
            m_tlast     = (ack_step_reg == 2'd3);
            case (ack_step_reg)
                2'd0:    byte_out = ACK_CTRL;
                2'd1:    byte_out = seq_reg;
                2'd2:    byte_out = 8'd0;
                default: byte_out = {ack_nib_reg, 4'd0};
            endcase
        end

        m_tvalid = busy_reg;
        m_tdata  = {6'd0, verdict_out, byte_out};
        m_tuser  = kind;
        xfer     = busy_reg && m_tready;
        free     = !busy_reg || (xfer && m_tlast);

        // advance through the result list one transfer at a time
        busy_next         = busy_reg && !(xfer && m_tlast);
        pend_payload_next = pend_payload_reg && !xfer;
        ack_step_next     = ack_step_reg;
        if (xfer && !pend_payload_reg && !m_tlast)
        begin
            ack_step_next = ack_step_reg + 2'd1;
        end
        if (load)
        begin
            busy_next         = 1'b1;
            pend_payload_next = bundle.payload_valid;
            ack_step_next     = 2'd0;
        end
        else if (!busy_next)
        begin
            ack_step_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            pend_payload_reg <= 1'b0;
            ack_step_reg     <= 2'd0;
            verdict_reg      <= VERDICT_PENDING;
        end
        else
        begin
            busy_reg         <= busy_next;
            pend_payload_reg <= pend_payload_next;
            ack_step_reg     <= ack_step_next;
            if (load)
            begin
                verdict_reg <= bundle.verdict;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            payload_reg <= bundle.payload;
            seq_reg     <= bundle.seq;
            ack_nib_reg <= bundle.ack_nib;
        end
    end

    // a held bundle without a verdict must still carry a payload byte
    a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && verdict_reg == VERDICT_PENDING |-> pend_payload_reg)
        else $error("emitter holds an empty bundle");

    // ack steps only run for an acknowledged segment after its payload
    a_ack_step: assert property (@(posedge clk) disable iff (!rst_n)
        ack_step_reg != 2'd0 |-> busy_reg && !pend_payload_reg &&
            (verdict_reg == VERDICT_ACCEPTED || verdict_reg == VERDICT_DUPLICATE))
        else $error("ack step outside an acknowledgement");

    // a transfer that is not the end of a run is followed by more results
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("result run cut short");

    // a new bundle is only taken when the emitter is idle or its current one is finishing
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("bundle loaded over pending results");

endmodule

`default_nettype wire
